/* rtl/core/assert_macros.svh */
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* rtl/core/wssr_pkg.sv */
`timescale 1ns / 1ps
package wssr_pkg;

    localparam int PERIOD_W = 16;
    localparam int SUM_W    = 22;
    localparam int SPEED_W  = 16;
    localparam int DUTY_W   = 14;
    localparam int TGT_W    = 10;
    localparam int DB_W     = 8;
    localparam int STEP_W   = 10;
    localparam int CFG_W    = 14;
    localparam int IDX_W    = 3;

    localparam logic [SUM_W-1:0]   SPEED_NUM  = 22'd2000000;
    localparam logic [SPEED_W-1:0] SPEED_MAX  = 16'd65535;
    localparam logic [DUTY_W-1:0]  DUTY_MAX   = 14'd16383;
    localparam logic [DUTY_W-1:0]  DUTY_RESET = 14'd3750;

    localparam logic [TGT_W-1:0]  TARGET_RESET   = 10'd50;
    localparam logic [DB_W-1:0]   DEADBAND_RESET = 8'd3;
    localparam logic [STEP_W-1:0] STEP_RESET     = 10'd100;
    localparam logic [DUTY_W-1:0] CEILING_RESET  = 14'd14898;

    localparam logic [IDX_W-1:0] REG_TARGET_L = 3'd0;
    localparam logic [IDX_W-1:0] REG_TARGET_R = 3'd1;
    localparam logic [IDX_W-1:0] REG_DEADBAND = 3'd2;
    localparam logic [IDX_W-1:0] REG_STEP     = 3'd3;
    localparam logic [IDX_W-1:0] REG_CEILING  = 3'd4;

    typedef enum logic {
        S_ACC,
        S_CALC
    } t_top_state;

    typedef enum logic [2:0] {
        L_IDLE,
        L_START,
        L_AVG,
        L_SPD,
        L_REG,
        L_DONE
    } t_lane_state;

    typedef struct packed {
        logic add;
        logic last;
        logic ack;
    } t_lane_ctl;

    typedef struct packed {
        logic [TGT_W-1:0]  target;
        logic [DB_W-1:0]   deadband;
        logic [STEP_W-1:0] step;
        logic [DUTY_W-1:0] ceiling;
    } t_lane_cfg;

endpackage

/* rtl/core/wssr_div.sv */
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module wssr_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [wssr_pkg::SUM_W-1:0]     i_dividend,
    input  logic [wssr_pkg::SPEED_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [wssr_pkg::SUM_W-1:0]     o_quot
);
    localparam int NUM_W = wssr_pkg::SUM_W;
    localparam int DEN_W = wssr_pkg::SPEED_W;
    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_quot, n_quot;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_fit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_den  <= n_den;
    end

    always_comb begin
        w_trial = {r_rem, r_quot[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_fit   = (w_trial >= {1'b0, r_den});
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quot  = r_quot;
        n_den   = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quot = i_dividend;
            n_den  = i_divisor;
        end else if (r_busy) begin
            n_rem  = w_fit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            n_quot = {r_quot[NUM_W-2:0], w_fit};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* rtl/core/wssr_lane.sv */
`timescale 1ns / 1ps
// one wheel: period sum, average and speed divisions, duty update
module wssr_lane #(
    parameter int WINDOW = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wssr_pkg::t_lane_ctl             i_ctl,
    input  wssr_pkg::t_lane_cfg             i_cfg,
    input  logic [wssr_pkg::PERIOD_W-1:0]   i_period,
    output logic                            o_done,
    output logic [wssr_pkg::SPEED_W-1:0]    o_speed,
    output logic [wssr_pkg::DUTY_W-1:0]     o_duty
);
    localparam int SUM_W   = wssr_pkg::SUM_W;
    localparam int SPEED_W = wssr_pkg::SPEED_W;
    localparam int DUTY_W  = wssr_pkg::DUTY_W;
    localparam int TGT_W   = wssr_pkg::TGT_W;

    wssr_pkg::t_lane_state r_state, n_state;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [SPEED_W-1:0] r_speed, n_speed;
    logic [DUTY_W-1:0]  r_duty, n_duty;

    logic               w_div_start;
    logic [SUM_W-1:0]   w_div_num;
    logic [SPEED_W-1:0] w_div_den;
    logic               w_div_done;
    logic [SUM_W-1:0]   w_div_quot;

    logic [TGT_W:0]     w_hi;
    logic [TGT_W:0]     w_lo;
    logic               w_lo_ok;
    logic               w_dec;
    logic               w_inc;
    logic [DUTY_W:0]    w_up;

    wssr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wssr_pkg::L_IDLE;
            r_sum   <= '0;
            r_duty  <= wssr_pkg::DUTY_RESET;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_duty  <= n_duty;
        end
        r_speed <= n_speed;
    end

    always_comb begin
        w_hi    = {1'b0, i_cfg.target} + (TGT_W+1)'(i_cfg.deadband);
        w_lo    = {1'b0, i_cfg.target} - (TGT_W+1)'(i_cfg.deadband);
        w_lo_ok = ({1'b0, i_cfg.target} >= (TGT_W+1)'(i_cfg.deadband));
        w_dec   = (r_speed > SPEED_W'(w_hi)) && (r_duty > DUTY_W'(i_cfg.step));
        w_inc   = w_lo_ok && (r_speed < SPEED_W'(w_lo)) && (r_duty < i_cfg.ceiling);
        w_up    = {1'b0, r_duty} + (DUTY_W+1)'(i_cfg.step);
    end

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_speed     = r_speed;
        n_duty      = r_duty;
        w_div_start = 1'b0;
        w_div_num   = r_sum;
        w_div_den   = SPEED_W'(WINDOW);
        if (i_ctl.add) begin
            n_sum = r_sum + SUM_W'(i_period);
        end
        unique case (r_state)
            wssr_pkg::L_IDLE: begin
                if (i_ctl.add && i_ctl.last) begin
                    n_state = wssr_pkg::L_START;
                end
            end
            wssr_pkg::L_START: begin
                w_div_start = 1'b1;
                n_sum       = '0;
                n_state     = wssr_pkg::L_AVG;
            end
            wssr_pkg::L_AVG: begin
                if (w_div_done) begin
                    if (w_div_quot == '0) begin
                        n_speed = wssr_pkg::SPEED_MAX;
                        n_state = wssr_pkg::L_REG;
                    end else begin
                        w_div_start = 1'b1;
                        w_div_num   = wssr_pkg::SPEED_NUM;
                        w_div_den   = w_div_quot[SPEED_W-1:0];
                        n_state     = wssr_pkg::L_SPD;
                    end
                end
            end
            wssr_pkg::L_SPD: begin
                if (w_div_done) begin
                    n_speed = (|w_div_quot[SUM_W-1:SPEED_W]) ? wssr_pkg::SPEED_MAX
                                                             : w_div_quot[SPEED_W-1:0];
                    n_state = wssr_pkg::L_REG;
                end
            end
            wssr_pkg::L_REG: begin
                if (w_dec) begin
                    n_duty = r_duty - DUTY_W'(i_cfg.step);
                end else if (w_inc) begin
                    n_duty = w_up[DUTY_W] ? wssr_pkg::DUTY_MAX : w_up[DUTY_W-1:0];
                end
                n_state = wssr_pkg::L_DONE;
            end
            wssr_pkg::L_DONE: begin
                if (i_ctl.ack) begin
                    n_state = wssr_pkg::L_IDLE;
                end
            end
            default: begin
                n_state = wssr_pkg::L_IDLE;
            end
        endcase
    end

    assign o_done  = (r_state == wssr_pkg::L_DONE);
    assign o_speed = r_speed;
    assign o_duty  = r_duty;

endmodule

/* rtl/core/wheel_speed_step_regulator_top.sv */
// A window-closing request gives its result after two bit-serial divisions
// per wheel, or after one when both averages are zero.
// Throughput: one request per cycle inside a window; after the closing
// request input stays blocked until the per-wheel restoring dividers finish,
// and longer while the previous result still waits.
// Reset: synchronous, active low; sums, count clear, duties 3750, regs reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wheel_speed_step_regulator_top #(
    parameter int WINDOW = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wssr_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [wssr_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [wssr_pkg::PERIOD_W-1:0]       i_left_period,
    input  logic [wssr_pkg::PERIOD_W-1:0]       i_right_period,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [wssr_pkg::SPEED_W-1:0]        o_left_speed,
    output logic [wssr_pkg::SPEED_W-1:0]        o_right_speed,
    output logic [wssr_pkg::DUTY_W-1:0]         o_left_drive,
    output logic [wssr_pkg::DUTY_W-1:0]         o_right_drive
);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int SPEED_W = wssr_pkg::SPEED_W;
    localparam int DUTY_W  = wssr_pkg::DUTY_W;

    wssr_pkg::t_top_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    logic [SPEED_W-1:0] r_left_speed, r_right_speed;
    logic [DUTY_W-1:0]  r_left_drive, r_right_drive;

    logic [wssr_pkg::TGT_W-1:0]  r_target_l, r_target_r;
    logic [wssr_pkg::DB_W-1:0]   r_deadband;
    logic [wssr_pkg::STEP_W-1:0] r_step;
    logic [DUTY_W-1:0]           r_ceiling;

    wssr_pkg::t_lane_ctl w_ctl;
    wssr_pkg::t_lane_cfg w_cfg_l, w_cfg_r;
    logic               w_accept;
    logic               w_load;
    logic               w_left_done, w_right_done;
    logic [SPEED_W-1:0] w_left_speed, w_right_speed;
    logic [DUTY_W-1:0]  w_left_duty, w_right_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_l <= wssr_pkg::TARGET_RESET;
            r_target_r <= wssr_pkg::TARGET_RESET;
            r_deadband <= wssr_pkg::DEADBAND_RESET;
            r_step     <= wssr_pkg::STEP_RESET;
            r_ceiling  <= wssr_pkg::CEILING_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wssr_pkg::REG_TARGET_L: r_target_l <= i_cfg_data[wssr_pkg::TGT_W-1:0];
                wssr_pkg::REG_TARGET_R: r_target_r <= i_cfg_data[wssr_pkg::TGT_W-1:0];
                wssr_pkg::REG_DEADBAND: r_deadband <= i_cfg_data[wssr_pkg::DB_W-1:0];
                wssr_pkg::REG_STEP:     r_step     <= i_cfg_data[wssr_pkg::STEP_W-1:0];
                wssr_pkg::REG_CEILING:  r_ceiling  <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_cfg_l = '{target: r_target_l, deadband: r_deadband, step: r_step,
                    ceiling: r_ceiling};
        w_cfg_r = '{target: r_target_r, deadband: r_deadband, step: r_step,
                    ceiling: r_ceiling};
    end

    wssr_lane #(.WINDOW(WINDOW)) u_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_cfg    (w_cfg_l),
        .i_period (i_left_period),
        .o_done   (w_left_done),
        .o_speed  (w_left_speed),
        .o_duty   (w_left_duty)
    );

    wssr_lane #(.WINDOW(WINDOW)) u_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_cfg    (w_cfg_r),
        .i_period (i_right_period),
        .o_done   (w_right_done),
        .o_speed  (w_right_speed),
        .o_duty   (w_right_duty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wssr_pkg::S_ACC;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        if (w_load) begin
            r_left_speed  <= w_left_speed;
            r_right_speed <= w_right_speed;
            r_left_drive  <= w_left_duty;
            r_right_drive <= w_right_duty;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        o_in_ready  = 1'b0;
        w_accept    = 1'b0;
        w_load      = 1'b0;
        w_ctl       = '0;
        unique case (r_state)
            wssr_pkg::S_ACC: begin
                o_in_ready = 1'b1;
                w_accept   = i_in_valid;
                w_ctl.add  = i_in_valid;
                if (i_in_valid) begin
                    if (r_count == CNT_W'(WINDOW - 1)) begin
                        w_ctl.last = 1'b1;
                        n_count    = '0;
                        n_state    = wssr_pkg::S_CALC;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            wssr_pkg::S_CALC: begin
                if (w_left_done && w_right_done && (!r_out_valid || i_out_ready)) begin
                    w_load    = 1'b1;
                    w_ctl.ack = 1'b1;
                    n_state   = wssr_pkg::S_ACC;
                end
            end
            default: begin
                n_state = wssr_pkg::S_ACC;
            end
        endcase
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_speed  = r_left_speed;
    assign o_right_speed = r_right_speed;
    assign o_left_drive  = r_left_drive;
    assign o_right_drive = r_right_drive;

    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(WINDOW - 1))
    `ASSERT_NEVER(a_no_accept_busy, i_clk, i_rst_n, w_accept && (w_left_done || w_right_done))
    `ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_load, o_out_valid && !w_left_done)
    `ASSERT_IMPL(a_close_window, i_clk, i_rst_n, w_ctl.last, w_accept)

endmodule
